// ===== rtl/vlcd_pkg.sv =====
// shared types, constants and codes of the calibrated vibration level detector
// no dependencies; imported by vlcd_cfg, vlcd_div and vibration_level_calibrated_detector
package vlcd_pkg;

  // default values of the top level parameters
  localparam int SAMPLE_BITS      = 12;
  localparam int EVENT_COUNT_BITS = 24;

  // field widths
  localparam int REQ_W      = 2;
  localparam int MV_W       = 12;
  localparam int RAW_W      = 12;
  localparam int TICK_W     = 20;
  localparam int EVNUM_W    = 24;
  localparam int CV_W       = 9;
  localparam int PCT_W      = 7;
  localparam int LEVEL_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_MARGIN_MV  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_FLOOR_MV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_IDLE_MV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_WARN_MV   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_PCT_MIN   = 3'd5;

  // configuration reset values
  localparam logic [16:0] RST_CAL_SAMPLES     = 17'd50000;
  localparam logic [7:0]  RST_IDLE_MARGIN_MV  = 8'd5;
  localparam logic [9:0]  RST_LOW_FLOOR_MV    = 10'd100;
  localparam logic [11:0] RST_NOMINAL_IDLE_MV = 12'd3188;
  localparam logic [9:0]  RST_DRIFT_WARN_MV   = 10'd50;
  localparam logic [6:0]  RST_EVENT_PCT_MIN   = 7'd1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_SAMPLE    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP      = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLR_COUNT = 2'd3;

  // result kinds
  localparam logic KIND_EVENT  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // operating phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CAL  = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;

  // shared divider: quotient register, divisor and step counter widths
  localparam int QUO_W      = 37;
  localparam int DIV_W      = 17;
  localparam int DIV_CNT_W  = 6;
  localparam logic [DIV_CNT_W-1:0] MEAN_STEPS = 6'd37;
  localparam logic [DIV_CNT_W-1:0] PCT_STEPS  = 6'd7;

  // reciprocal of ten in 0.16 fixed point, exact for inputs below 16384
  localparam logic [12:0] CV_RECIP = 13'd6554;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [MV_W-1:0]   sample_mv;
    logic [RAW_W-1:0]  sample_raw;
    logic [TICK_W-1:0] tick_offset;
  } vlcd_in_t;

  typedef struct packed {
    logic               result_kind;
    logic [EVNUM_W-1:0] event_number;
    logic [TICK_W-1:0]  event_tick;
    logic [CV_W-1:0]    centivolts;
    logic [RAW_W-1:0]   raw_count;
    logic [PCT_W-1:0]   amplitude_pct;
    logic [LEVEL_W-1:0] mean_level;
    logic [LEVEL_W-1:0] noise_half;
    logic [LEVEL_W-1:0] zero_level_out;
    logic               drift_warning;
  } vlcd_out_t;

  typedef struct packed {
    logic [16:0] cal_samples;
    logic [7:0]  idle_margin_mv;
    logic [9:0]  low_floor_mv;
    logic [11:0] nominal_idle_mv;
    logic [9:0]  drift_warn_mv;
    logic [6:0]  event_pct_min;
  } vlcd_cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_W-1:0]     rem_init;
    logic [QUO_W-1:0]     quo_init;
    logic [DIV_W-1:0]     divisor;
  } vlcd_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } vlcd_div_rsp_t;

endpackage

// ===== rtl/vlcd_cfg.sv =====
// configuration register file of the vibration level detector
// depends on vlcd_pkg
module vlcd_cfg import vlcd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output vlcd_cfg_t             cfg_o
);

  vlcd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_samples     <= RST_CAL_SAMPLES;
      cfg_q.idle_margin_mv  <= RST_IDLE_MARGIN_MV;
      cfg_q.low_floor_mv    <= RST_LOW_FLOOR_MV;
      cfg_q.nominal_idle_mv <= RST_NOMINAL_IDLE_MV;
      cfg_q.drift_warn_mv   <= RST_DRIFT_WARN_MV;
      cfg_q.event_pct_min   <= RST_EVENT_PCT_MIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAL_SAMPLES:     cfg_q.cal_samples     <= cfg_data_i;
        CFG_IDLE_MARGIN_MV:  cfg_q.idle_margin_mv  <= cfg_data_i[7:0];
        CFG_LOW_FLOOR_MV:    cfg_q.low_floor_mv    <= cfg_data_i[9:0];
        CFG_NOMINAL_IDLE_MV: cfg_q.nominal_idle_mv <= cfg_data_i[11:0];
        CFG_DRIFT_WARN_MV:   cfg_q.drift_warn_mv   <= cfg_data_i[9:0];
        CFG_EVENT_PCT_MIN:   cfg_q.event_pct_min   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/vlcd_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on vlcd_pkg; used for the calibrated mean and the amplitude percent
module vlcd_div import vlcd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vlcd_div_req_t req_i,
  output vlcd_div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     rem_q;
  logic [QUO_W-1:0]     quo_q;
  logic [DIV_W-1:0]     div_q;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           fits;

  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      quo_q <= req_i.quo_init;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== rtl/vibration_level_calibrated_detector.sv =====
// calibrated vibration level detector, top level with the sequencer
// depends on vlcd_pkg, vlcd_cfg and vlcd_div
//
// The block takes one word at a time: a sample (millivolts, raw count, tick)
// or a command (start calibration, stop, reset event count). Start clears the
// calibration sums and the event count; the next cal_samples samples (at
// least one) are summed and their min and max tracked, then a report word
// gives the mean, half the peak-to-peak noise, the zero-percent level and a
// drift flag (all in 1/16 mV). While running, each sample is mapped between
// the zero level (0 %) and low_floor_mv (100 %); a sample above event_pct_min
// gives a numbered event word. A single restoring divider does the mean and
// percent division at one bit per cycle. in_stall_o is high while a word is
// being worked on: a command or an ignored sample goes only through decode,
// a calibration sample through decode and the window check, a running sample
// through decode, prepare, start, the divider (7 divider steps, skipped
// outside the span), finish and, for an event, emit, and the window's closing
// sample through decode, the window check, the mean division (37 steps), post,
// done and emit. Emit waits while the output register is full and stalled. A
// finished result sits in an output register, so the next word is taken
// while it waits; a new result waits until that register is free. Configuration
// is written through cfg_we_i / cfg_idx_i / cfg_data_i, by the user only while
// the block is idle; the block does not enforce this.
module vibration_level_calibrated_detector import vlcd_pkg::*; #(
  parameter int SampleBits     = SAMPLE_BITS,
  parameter int EventCountBits = EVENT_COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  vlcd_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output vlcd_out_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NoiseW = SampleBits + 3;

  // sequencer states
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_DECODE    = 4'd1;
  localparam logic [3:0] ST_CAL_CHK   = 4'd2;
  localparam logic [3:0] ST_MEAN_DIV  = 4'd3;
  localparam logic [3:0] ST_MEAN_POST = 4'd4;
  localparam logic [3:0] ST_CAL_DONE  = 4'd5;
  localparam logic [3:0] ST_PCT_PREP  = 4'd6;
  localparam logic [3:0] ST_PCT_START = 4'd7;
  localparam logic [3:0] ST_PCT_DIV   = 4'd8;
  localparam logic [3:0] ST_PCT_FIN   = 4'd9;
  localparam logic [3:0] ST_EMIT      = 4'd10;

  logic [3:0] state_q, state_d;

  vlcd_cfg_t     cfg;
  vlcd_div_req_t div_req;
  vlcd_div_rsp_t div_rsp;

  // architectural state
  logic [1:0]                phase_q;
  logic [31:0]               cal_sum_q;
  logic [16:0]               cal_count_q;
  logic [SampleBits-1:0]     cal_min_q;
  logic [SampleBits-1:0]     cal_max_q;
  logic [LEVEL_W-1:0]        zero_level_q;
  logic [EventCountBits-1:0] event_count_q;
  logic                      out_valid_q;

  // working registers
  vlcd_in_t           item_q;
  logic signed [17:0] span_raw_q;
  logic signed [21:0] num_raw_q;
  logic [15:0]        span_q;
  logic [NoiseW-1:0]  noise_q;
  logic [QUO_W-1:0]   mean_q;
  logic signed [38:0] zc_q;
  logic signed [38:0] dd_q;
  logic [PCT_W-1:0]   pct_q;
  vlcd_out_t          res_q;
  vlcd_out_t          out_data_q;

  logic accept;
  logic out_free;

  vlcd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  vlcd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // sample masked to SampleBits, kept at 16 bits for arithmetic
  logic [15:0]           sample_ext;
  logic [SampleBits-1:0] mv_w;
  logic [15:0]           mv16;
  assign sample_ext = 16'(item_q.sample_mv);
  assign mv_w       = sample_ext[SampleBits-1:0];
  assign mv16       = 16'(mv_w);

  // calibration accumulation
  logic [32:0] sum_ext;
  assign sum_ext = {1'b0, cal_sum_q} + 33'(mv16);

  logic cal_full;
  assign cal_full = (cal_count_q >= cfg.cal_samples);

  // mean dividend: 16 * sum + n / 2
  logic [QUO_W-1:0] mean_dvd;
  assign mean_dvd = QUO_W'({cal_sum_q, 4'b0}) + QUO_W'(cal_count_q[16:1]);

  // percent: 100 * num / span rounded, as (200 * num + span) / (2 * span)
  logic        num_le0;
  logic        num_ge_span;
  logic [15:0] num16;
  logic [24:0] pct_dvd;
  assign num_le0     = (num_raw_q <= 22'sd0);
  assign num_ge_span = (num_raw_q >= $signed({6'b0, span_q}));
  assign num16       = num_raw_q[15:0];
  assign pct_dvd     = 25'(num16) * 25'd200 + 25'(span_q);

  always_comb begin
    div_req = '0;
    if (state_q == ST_CAL_CHK) begin
      div_req.start    = cal_full;
      div_req.steps    = MEAN_STEPS;
      div_req.rem_init = '0;
      div_req.quo_init = mean_dvd;
      div_req.divisor  = cal_count_q;
    end else if (state_q == ST_PCT_START) begin
      // quotient stays below 128, so only the last seven steps are run
      div_req.start    = !num_le0 && !num_ge_span;
      div_req.steps    = PCT_STEPS;
      div_req.rem_init = pct_dvd[23:7];
      div_req.quo_init = {pct_dvd[6:0], (QUO_W - 7)'(0)};
      div_req.divisor  = {span_q, 1'b0};
    end
  end

  // calibration end arithmetic
  logic signed [38:0] floor16;
  logic signed [38:0] zero_sel;
  logic [15:0]        zero16;
  logic signed [38:0] d_abs;
  logic [31:0]        noise_ext;
  logic [15:0]        mean16;
  logic [15:0]        noise16;
  assign floor16   = $signed(39'({11'(cfg.low_floor_mv) + 11'd50, 4'b0}));
  assign zero_sel  = (zc_q < floor16) ? floor16 : zc_q;
  assign zero16    = (zero_sel > 39'sd65535) ? 16'hFFFF : zero_sel[15:0];
  assign d_abs     = dd_q[38] ? -dd_q : dd_q;
  assign noise_ext = 32'(noise_q);
  assign noise16   = (|noise_ext[31:16]) ? 16'hFFFF : noise_ext[15:0];
  assign mean16    = (|mean_q[QUO_W-1:16]) ? 16'hFFFF : mean_q[15:0];

  // centivolts, (mv + 5) / 10 by reciprocal
  logic [12:0] cv_in;
  logic [25:0] cv_prod;
  assign cv_in   = 13'(mv16[11:0]) + 13'd5;
  assign cv_prod = 26'(cv_in) * 26'(CV_RECIP);

  logic [31:0] evnum_ext;
  assign evnum_ext = 32'(event_count_q);

  vlcd_out_t res_evt;
  vlcd_out_t res_cal;

  always_comb begin
    res_evt               = '0;
    res_evt.result_kind   = KIND_EVENT;
    res_evt.event_number  = evnum_ext[EVNUM_W-1:0];
    res_evt.event_tick    = item_q.tick_offset;
    res_evt.centivolts    = cv_prod[CV_W+15:16];
    res_evt.raw_count     = item_q.sample_raw;
    res_evt.amplitude_pct = pct_q;
  end

  always_comb begin
    res_cal                = '0;
    res_cal.result_kind    = KIND_REPORT;
    res_cal.mean_level     = mean16;
    res_cal.noise_half     = noise16;
    res_cal.zero_level_out = zero16;
    res_cal.drift_warning  = (d_abs > $signed(39'({cfg.drift_warn_mv, 4'b0})));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (accept) state_d = ST_DECODE;
      ST_DECODE: begin
        state_d = ST_IDLE;
        if (item_q.req_type == REQ_SAMPLE) begin
          if (phase_q == PH_CAL) state_d = ST_CAL_CHK;
          else if (phase_q == PH_RUN) state_d = ST_PCT_PREP;
        end
      end
      ST_CAL_CHK:   state_d = cal_full ? ST_MEAN_DIV : ST_IDLE;
      ST_MEAN_DIV:  if (div_rsp.done) state_d = ST_MEAN_POST;
      ST_MEAN_POST: state_d = ST_CAL_DONE;
      ST_CAL_DONE:  state_d = ST_EMIT;
      ST_PCT_PREP:  state_d = ST_PCT_START;
      ST_PCT_START: state_d = (num_le0 || num_ge_span) ? ST_PCT_FIN : ST_PCT_DIV;
      ST_PCT_DIV:   if (div_rsp.done) state_d = ST_PCT_FIN;
      ST_PCT_FIN:   state_d = (pct_q > cfg.event_pct_min) ? ST_EMIT : ST_IDLE;
      ST_EMIT:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= PH_IDLE;
      cal_sum_q     <= '0;
      cal_count_q   <= '0;
      cal_min_q     <= '1;
      cal_max_q     <= '0;
      zero_level_q  <= '0;
      event_count_q <= EventCountBits'(1);
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == ST_DECODE) begin
        unique case (item_q.req_type)
          REQ_START: begin
            cal_sum_q     <= '0;
            cal_count_q   <= '0;
            cal_min_q     <= '1;
            cal_max_q     <= '0;
            event_count_q <= EventCountBits'(1);
            phase_q       <= PH_CAL;
          end
          REQ_STOP:      phase_q <= PH_IDLE;
          REQ_CLR_COUNT: event_count_q <= EventCountBits'(1);
          REQ_SAMPLE: begin
            if (phase_q == PH_CAL) begin
              cal_sum_q <= sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
              if (cal_count_q != '1) cal_count_q <= cal_count_q + 1'b1;
              if (mv_w < cal_min_q) cal_min_q <= mv_w;
              if (mv_w > cal_max_q) cal_max_q <= mv_w;
            end
          end
          default: ;
        endcase
      end

      if (state_q == ST_CAL_DONE) begin
        zero_level_q <= zero16;
        phase_q      <= PH_RUN;
      end

      // event numbers saturate at all ones
      if (state_q == ST_PCT_FIN && pct_q > cfg.event_pct_min &&
          event_count_q != '1) begin
        event_count_q <= event_count_q + 1'b1;
      end

      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;

    if (state_q == ST_DECODE) begin
      span_raw_q <= $signed({2'b0, zero_level_q}) - $signed({4'b0, cfg.low_floor_mv, 4'b0});
      num_raw_q  <= $signed({6'b0, zero_level_q}) - $signed({2'b0, mv16, 4'b0});
    end

    if (state_q == ST_CAL_CHK) begin
      noise_q <= (cal_max_q >= cal_min_q) ? {cal_max_q - cal_min_q, 3'b0} : '0;
    end

    if (state_q == ST_MEAN_DIV && div_rsp.done) mean_q <= div_rsp.quo;

    if (state_q == ST_MEAN_POST) begin
      zc_q <= $signed({2'b0, mean_q}) - $signed(39'(noise_q))
            - $signed(39'({cfg.idle_margin_mv, 4'b0}));
      dd_q <= $signed({2'b0, mean_q}) - $signed(39'({cfg.nominal_idle_mv, 4'b0}));
    end

    // span is held at 50 mV or more
    if (state_q == ST_PCT_PREP) begin
      span_q <= (span_raw_q < 18'sd800) ? 16'd800 : span_raw_q[15:0];
    end

    if (state_q == ST_PCT_START) begin
      if (num_le0) pct_q <= '0;
      else if (num_ge_span) pct_q <= PCT_W'(100);
    end

    if (state_q == ST_PCT_DIV && div_rsp.done) begin
      pct_q <= (div_rsp.quo > QUO_W'(100)) ? PCT_W'(100) : div_rsp.quo[PCT_W-1:0];
    end

    if (state_q == ST_CAL_DONE) res_q <= res_cal;
    if (state_q == ST_PCT_FIN) res_q <= res_evt;

    if (state_q == ST_EMIT && out_free) out_data_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== dv/tb_vibration_level_calibrated_detector.sv =====
`timescale 1ns / 100ps
// testbench of the calibrated vibration level detector: directed and random words
// checked against an in-bench detector model; needs vlcd_pkg and the detector rtl
module tb_vibration_level_calibrated_detector;
  import vlcd_pkg::*;

  // pause before a register write: covers the longest word (mean division)
  localparam int SETTLE_CYCLES  = 64;
  // cycles with no handshake on either side before the run is declared hung
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int LONG_WINDOW    = 200;
  localparam int MAX_PRINTED    = 50;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  vlcd_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  vlcd_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // random idling of the sender and the receiver
  bit idle_en  = 1'b1;
  bit stall_en = 1'b1;

  int mismatches = 0;
  int words_sent = 0;
  int quiet_cycles = 0;

  // expected event and report words, oldest first
  vlcd_out_t due_words[$];

  // detector model state and its copy of the registers
  logic [1:0]  m_phase;
  logic [31:0] m_sum;
  logic [16:0] m_count;
  logic [11:0] m_min;
  logic [11:0] m_max;
  logic [15:0] m_zero;
  logic [23:0] m_events;
  vlcd_cfg_t   m_cfg;

  always #4 clk = ~clk;

  vibration_level_calibrated_detector dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // receiver back-pressure, about a quarter of the cycles when enabled
  always @(posedge clk) begin
    out_stall <= stall_en && ($urandom_range(0, 99) < 24);
  end

  // ---------------------------------------------------------------------------
  // detector model
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] sat16(input longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic void clear_window();
    m_sum   = '0;
    m_count = '0;
    m_min   = 12'hFFF;
    m_max   = '0;
  endfunction

  function automatic void model_reset();
    m_cfg.cal_samples     = RST_CAL_SAMPLES;
    m_cfg.idle_margin_mv  = RST_IDLE_MARGIN_MV;
    m_cfg.low_floor_mv    = RST_LOW_FLOOR_MV;
    m_cfg.nominal_idle_mv = RST_NOMINAL_IDLE_MV;
    m_cfg.drift_warn_mv   = RST_DRIFT_WARN_MV;
    m_cfg.event_pct_min   = RST_EVENT_PCT_MIN;
    m_phase  = PH_IDLE;
    clear_window();
    m_zero   = '0;
    m_events = 24'd1;
  endfunction

  // one accepted word in, at most one expected word out
  function automatic void detect_step(input vlcd_in_t w, output bit has, output vlcd_out_t r);
    logic [32:0]     acc;
    longint unsigned n;
    longint unsigned mean_u;
    longint          mean, noise, zero, floor_lv, d, span, num, pct, cv;
    longint          hi, lo, mv, zl, lf, margin, nominal, drift, pct_min;
    has = 1'b0;
    r   = '0;
    mv      = longint'(w.sample_mv);
    lf      = longint'(m_cfg.low_floor_mv);
    margin  = longint'(m_cfg.idle_margin_mv);
    nominal = longint'(m_cfg.nominal_idle_mv);
    drift   = longint'(m_cfg.drift_warn_mv);
    pct_min = longint'(m_cfg.event_pct_min);
    if (w.req_type == REQ_START) begin
      clear_window();
      m_events = 24'd1;
      m_phase  = PH_CAL;
    end else if (w.req_type == REQ_STOP) begin
      m_phase = PH_IDLE;
    end else if (w.req_type == REQ_CLR_COUNT) begin
      m_events = 24'd1;
    end else if (m_phase == PH_CAL) begin
      acc   = {1'b0, m_sum} + {21'd0, w.sample_mv};
      m_sum = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
      if (m_count != 17'h1FFFF) m_count++;
      if (w.sample_mv < m_min) m_min = w.sample_mv;
      if (w.sample_mv > m_max) m_max = w.sample_mv;
      // the closing sample only closes the window, it is not rated
      if (m_count >= m_cfg.cal_samples) begin
        n      = (m_count == 0) ? 64'd1 : 64'(m_count);
        mean_u = (64'(m_sum) * 16 + n / 2) / n;
        mean   = $signed(mean_u);
        hi     = longint'(m_max);
        lo     = longint'(m_min);
        noise  = (hi >= lo) ? (hi - lo) * 8 : 0;
        zero   = mean - noise - margin * 16;
        floor_lv = (lf + 50) * 16;
        if (zero < floor_lv) zero = floor_lv;
        m_zero  = sat16(zero);
        m_phase = PH_RUN;
        d = mean - nominal * 16;
        if (d < 0) d = -d;
        has = 1'b1;
        r.result_kind    = KIND_REPORT;
        r.mean_level     = sat16(mean);
        r.noise_half     = sat16(noise);
        r.zero_level_out = m_zero;
        r.drift_warning  = (d > drift * 16);
      end
    end else if (m_phase == PH_RUN) begin
      zl   = longint'(m_zero);
      span = zl - lf * 16;
      if (span < 800) span = 800;
      num = zl - mv * 16;
      if (num <= 0) pct = 0;
      else if (num >= span) pct = 100;
      else pct = (200 * num + span) / (2 * span);
      cv = (mv + 5) / 10;
      if (pct > pct_min) begin
        has = 1'b1;
        r.result_kind   = KIND_EVENT;
        r.event_number  = m_events;
        r.event_tick    = w.tick_offset;
        r.centivolts    = cv[CV_W-1:0];
        r.raw_count     = w.sample_raw;
        r.amplitude_pct = pct[PCT_W-1:0];
        if (m_events != 24'hFF_FFFF) m_events++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking and watchdog, sampled at the falling edge where nothing moves
  // ---------------------------------------------------------------------------

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
  endtask

  task automatic check_field(input string nm, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report(nm, got, want);
  endtask

  always @(negedge clk) begin : check_words
    vlcd_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_words.size() == 0) begin
        report("word with nothing due, kind", 32'(out_data.result_kind), 32'd0);
      end else begin
        want = due_words.pop_front();
        check_field("result_kind", 32'(out_data.result_kind), 32'(want.result_kind));
        check_field("event_number", 32'(out_data.event_number), 32'(want.event_number));
        check_field("event_tick", 32'(out_data.event_tick), 32'(want.event_tick));
        check_field("centivolts", 32'(out_data.centivolts), 32'(want.centivolts));
        check_field("raw_count", 32'(out_data.raw_count), 32'(want.raw_count));
        check_field("amplitude_pct", 32'(out_data.amplitude_pct),
                    32'(want.amplitude_pct));
        check_field("mean_level", 32'(out_data.mean_level), 32'(want.mean_level));
        check_field("noise_half", 32'(out_data.noise_half), 32'(want.noise_half));
        check_field("zero_level_out", 32'(out_data.zero_level_out),
                    32'(want.zero_level_out));
        check_field("drift_warning", 32'(out_data.drift_warning),
                    32'(want.drift_warning));
      end
    end
  end

  always @(negedge clk) begin : watchdog
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL vibration_level_calibrated_detector");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  function automatic logic [TICK_W-1:0] rand_tick();
    // mostly inside the minute, sometimes anywhere in the field
    if ($urandom_range(0, 9) == 0) return TICK_W'($urandom_range(0, 20'hFFFFF));
    return TICK_W'($urandom_range(0, 599999));
  endfunction

  function automatic vlcd_in_t make_word(input logic [REQ_W-1:0] req, input int mv);
    vlcd_in_t w;
    w.req_type    = req;
    w.sample_mv   = mv[MV_W-1:0];
    w.sample_raw  = RAW_W'($urandom_range(0, 4095));
    w.tick_offset = rand_tick();
    return w;
  endfunction

  function automatic int near_level(input int level, input int spread);
    int v;
    v = level + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // send one word; valid stays high on return so back-to-back words need no gap
  task automatic send_word(input vlcd_in_t w);
    bit        take;
    bit        has;
    vlcd_out_t res;
    if (idle_en && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(negedge clk);
      take = (in_stall === 1'b0);
      @(posedge clk);
    end while (!take);
    // samples in idle are ignored by the block and are not counted
    if (w.req_type != REQ_SAMPLE || m_phase != PH_IDLE) words_sent++;
    detect_step(w, has, res);
    if (has) due_words.push_back(res);
  endtask

  // drop valid, wait for every due word, then let a slow word finish
  task automatic settle();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // call only after settle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_CAL_SAMPLES:     m_cfg.cal_samples     = val[16:0];
      CFG_IDLE_MARGIN_MV:  m_cfg.idle_margin_mv  = val[7:0];
      CFG_LOW_FLOOR_MV:    m_cfg.low_floor_mv    = val[9:0];
      CFG_NOMINAL_IDLE_MV: m_cfg.nominal_idle_mv = val[11:0];
      CFG_DRIFT_WARN_MV:   m_cfg.drift_warn_mv   = val[9:0];
      CFG_EVENT_PCT_MIN:   m_cfg.event_pct_min   = val[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input vlcd_cfg_t c);
    settle();
    write_reg(CFG_CAL_SAMPLES, int'(c.cal_samples));
    write_reg(CFG_IDLE_MARGIN_MV, int'(c.idle_margin_mv));
    write_reg(CFG_LOW_FLOOR_MV, int'(c.low_floor_mv));
    write_reg(CFG_NOMINAL_IDLE_MV, int'(c.nominal_idle_mv));
    write_reg(CFG_DRIFT_WARN_MV, int'(c.drift_warn_mv));
    write_reg(CFG_EVENT_PCT_MIN, int'(c.event_pct_min));
  endtask

  // register value biased toward both ends of its range
  function automatic int pick_reg(input int hi);
    int p;
    p = $urandom_range(0, 99);
    if (p < 15) return 0;
    if (p < 30) return hi;
    return $urandom_range(0, hi);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset state: samples in idle give nothing, commands other than start too
  task automatic test_idle_words();
    send_word('{REQ_SAMPLE, 12'd0, 12'd0, 20'd0});
    send_word('{REQ_SAMPLE, 12'hFFF, 12'hFFF, 20'hFFFFF});
    send_word(make_word(REQ_STOP, 1234));
    send_word(make_word(REQ_CLR_COUNT, 4095));
  endtask

  // short window near the nominal idle, then rated samples across the span
  task automatic test_first_calibration();
    vlcd_cfg_t c;
    c = '{17'd4, 8'd5, 10'd100, 12'd3188, 10'd50, 7'd1};
    apply_config(c);
    send_word(make_word(REQ_START, 0));
    send_word(make_word(REQ_SAMPLE, 3180));
    send_word(make_word(REQ_SAMPLE, 3196));
    send_word(make_word(REQ_SAMPLE, 3188));
    send_word(make_word(REQ_SAMPLE, 3190));
    // full scale, above the zero level, at the floor, small and sub-threshold
    send_word('{REQ_SAMPLE, 12'd0, 12'hFFF, 20'd599999});
    send_word('{REQ_SAMPLE, 12'hFFF, 12'd0, 20'd0});
    send_word(make_word(REQ_SAMPLE, 100));
    send_word(make_word(REQ_SAMPLE, 3100));
    send_word(make_word(REQ_SAMPLE, 3170));
    // count restart keeps the running phase
    send_word(make_word(REQ_CLR_COUNT, 0));
    send_word(make_word(REQ_SAMPLE, 50));
    // stopped: even a full-scale sample is ignored
    send_word(make_word(REQ_STOP, 0));
    send_word(make_word(REQ_SAMPLE, 0));
  endtask

  // empty window, restart while running, and a window cut short mid-way
  task automatic test_window_edges();
    settle();
    write_reg(CFG_CAL_SAMPLES, 0);
    send_word(make_word(REQ_START, 0));
    send_word(make_word(REQ_SAMPLE, 2000));
    send_word(make_word(REQ_SAMPLE, 0));
    send_word(make_word(REQ_START, 0));
    send_word(make_word(REQ_SAMPLE, 3900));
    settle();
    write_reg(CFG_CAL_SAMPLES, 10);
    send_word(make_word(REQ_START, 0));
    send_word(make_word(REQ_SAMPLE, 3000));
    send_word(make_word(REQ_SAMPLE, 3010));
    send_word(make_word(REQ_SAMPLE, 2990));
    settle();
    write_reg(CFG_CAL_SAMPLES, 2);
    send_word(make_word(REQ_SAMPLE, 3005));
    send_word(make_word(REQ_SAMPLE, 200));
  endtask

  // one random setting: calibrate, then a mix of rated samples and commands
  task automatic random_episode();
    vlcd_cfg_t c;
    vlcd_in_t  w;
    int        level, spread, run_len, p, lo, hi, mv;
    c.cal_samples     = 17'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12));
    c.idle_margin_mv  = 8'(($urandom_range(0, 1) == 0) ? pick_reg(255) :
                           $urandom_range(0, 20));
    c.low_floor_mv    = 10'(pick_reg(1023));
    c.drift_warn_mv   = 10'(pick_reg(1023));
    p = $urandom_range(0, 99);
    if (p < 15) c.event_pct_min = 7'd0;
    else if (p < 22) c.event_pct_min = 7'd100;
    else if (p < 27) c.event_pct_min = 7'd127;
    else c.event_pct_min = 7'($urandom_range(0, 40));
    level  = ($urandom_range(0, 4) == 0) ? pick_reg(4095) : $urandom_range(1000, 4095);
    spread = $urandom_range(0, 40);
    // nominal near the idle level about half the time so the drift flag goes both ways
    if ($urandom_range(0, 1) == 0) c.nominal_idle_mv = 12'(near_level(level, 60));
    else c.nominal_idle_mv = 12'(pick_reg(4095));
    apply_config(c);
    send_word(make_word(REQ_START, 0));
    repeat (c.cal_samples) send_word(make_word(REQ_SAMPLE, near_level(level, spread)));
    run_len = $urandom_range(20, 60);
    repeat (run_len) begin
      p = $urandom_range(0, 99);
      if (p < 4) begin
        send_word(make_word(REQ_CLR_COUNT, $urandom_range(0, 4095)));
      end else if (p < 6) begin
        send_word(make_word(REQ_STOP, $urandom_range(0, 4095)));
      end else if (p < 8) begin
        send_word(make_word(REQ_START, $urandom_range(0, 4095)));
      end else if (p < 11) begin
        w = make_word(REQ_SAMPLE, 0);
        w.req_type  = REQ_W'($urandom_range(0, 3));
        w.sample_mv = MV_W'($urandom_range(0, 4095));
        send_word(w);
      end else begin
        // about half inside the rated span, between the floor and the zero level
        lo = int'(m_cfg.low_floor_mv);
        hi = int'(m_zero / 16);
        if (hi > 4095) hi = 4095;
        if (p < 55 && lo <= hi) mv = $urandom_range(lo, hi);
        else if (p < 75) mv = near_level(level, spread + 20);
        else mv = $urandom_range(0, 4095);
        send_word(make_word(REQ_SAMPLE, mv));
      end
    end
  endtask

  task automatic test_random_traffic();
    int first;
    first = words_sent;
    while (words_sent - first < RANDOM_ITEMS) begin
      // a stretch in the middle runs with no idling on either side
      idle_en  = !((words_sent - first) > 500 && (words_sent - first) < 850);
      stall_en = idle_en;
      random_episode();
    end
    idle_en  = 1'b1;
    stall_en = 1'b1;
  endtask

  // long window of samples over the whole range, then rated samples
  task automatic test_long_window();
    vlcd_cfg_t c;
    c = '{17'(LONG_WINDOW), 8'd10, 10'd300, 12'd2048, 10'd20, 7'd5};
    apply_config(c);
    idle_en = 1'b0;
    send_word(make_word(REQ_START, 0));
    repeat (LONG_WINDOW) send_word(make_word(REQ_SAMPLE, $urandom_range(0, 4095)));
    repeat (6) send_word(make_word(REQ_SAMPLE, $urandom_range(0, 2000)));
    idle_en = 1'b1;
  endtask

  initial begin
    model_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_words();
    test_first_calibration();
    test_window_edges();
    test_random_traffic();
    test_long_window();
    settle();
    if (mismatches == 0) begin
      $display("PASS vibration_level_calibrated_detector");
    end else begin
      $display("FAIL vibration_level_calibrated_detector");
    end
    $finish;
  end

endmodule
